// ===== src/string_to_integer_parser_assert.svh =====
// assertion macros shared by the string-to-integer parser modules
// no dependencies; taken in by `include where a module checks itself
`ifndef STRING_TO_INTEGER_PARSER_ASSERT_SVH
`define STRING_TO_INTEGER_PARSER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define S2I_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("parser check failed");

// antecedent implies consequent in the next cycle
`define S2I_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

// ===== src/s2i_pkg.sv =====
// shared types and constants of the string-to-integer parser
// no dependencies; used by every module of the block
`default_nettype none

package s2i_pkg;

    // field widths
    localparam int VALUE_WIDTH     = 64;
    localparam int CHARS_WIDTH     = 16;
    localparam int BASE_WIDTH      = 6;
    localparam int CHAR_WIDTH      = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    // front-to-back queue
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    // register port
    localparam int APB_ADDR_WIDTH  = 3;
    localparam int APB_DATA_WIDTH  = 32;
    localparam logic [APB_ADDR_WIDTH-3:0] REG_NUMBER_BASE = '0;

    // radix codes
    localparam logic [BASE_WIDTH-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_WIDTH-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_WIDTH-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_WIDTH-1:0] BASE_RESET = 6'd10;

    // character codes
    localparam logic [CHAR_WIDTH-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CHAR_CR      = 8'h0D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_X = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_Z = 8'h7A;

    // input item
    typedef struct packed {
        logic                  string_start;
        logic [CHAR_WIDTH-1:0] character;
    } s2i_in_t;

    // result item
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] parsed_value;
        logic                          digits_seen;
        logic [CHARS_WIDTH-1:0]        chars_consumed;
    } s2i_out_t;

    // classified character as queued between front and back
    typedef struct packed {
        logic                  start;
        logic [BASE_WIDTH-1:0] base;
        logic                  is_space;
        logic                  is_sign;
        logic                  is_minus;
        logic                  is_zero;
        logic                  is_x;
        logic                  is_digit;
        logic [BASE_WIDTH-1:0] digit_val;
    } s2i_class_t;

endpackage

`default_nettype wire

// ===== src/s2i_front.sv =====
// front end: classifies each incoming character for the parse engine
// depends on s2i_pkg
`default_nettype none

module s2i_front (
    input  wire s2i_pkg::s2i_in_t                      in_data,
    input  wire logic [s2i_pkg::BASE_WIDTH-1:0]        number_base,
    output s2i_pkg::s2i_class_t                        cls
);

    logic [s2i_pkg::CHAR_WIDTH-1:0] c;
    logic is_dec;
    logic is_low;
    logic is_up;

    assign c = in_data.character;

    // character ranges
    assign is_dec = (c >= s2i_pkg::CHAR_ZERO) && (c <= s2i_pkg::CHAR_NINE);
    assign is_low = (c >= s2i_pkg::CHAR_LOWER_A) && (c <= s2i_pkg::CHAR_LOWER_Z);
    assign is_up  = (c >= s2i_pkg::CHAR_UPPER_A) && (c <= s2i_pkg::CHAR_UPPER_Z);

    // class flags and digit value
    always_comb begin
        cls.start    = in_data.string_start;
        cls.base     = number_base;
        cls.is_space = (c == s2i_pkg::CHAR_SPACE) ||
                       ((c >= s2i_pkg::CHAR_TAB) && (c <= s2i_pkg::CHAR_CR));
        cls.is_sign  = (c == s2i_pkg::CHAR_PLUS) || (c == s2i_pkg::CHAR_MINUS);
        cls.is_minus = (c == s2i_pkg::CHAR_MINUS);
        cls.is_zero  = (c == s2i_pkg::CHAR_ZERO);
        cls.is_x     = (c == s2i_pkg::CHAR_LOWER_X) || (c == s2i_pkg::CHAR_UPPER_X);
        cls.is_digit = is_dec || is_low || is_up;
        if (is_dec) begin
            cls.digit_val = s2i_pkg::BASE_WIDTH'(c - s2i_pkg::CHAR_ZERO);
        end else if (is_low) begin
            cls.digit_val = s2i_pkg::BASE_WIDTH'(c - s2i_pkg::CHAR_LOWER_A + 8'd10);
        end else if (is_up) begin
            cls.digit_val = s2i_pkg::BASE_WIDTH'(c - s2i_pkg::CHAR_UPPER_A + 8'd10);
        end else begin
            cls.digit_val = '0;
        end
    end

endmodule

`default_nettype wire

// ===== src/s2i_queue.sv =====
// short queue of classified characters between front and back
// depends on s2i_pkg
`default_nettype none

module s2i_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire s2i_pkg::s2i_class_t  in_entry,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output s2i_pkg::s2i_class_t       out_entry
);

    localparam int PW = s2i_pkg::QUEUE_PTR_WIDTH;
    localparam int CW = s2i_pkg::QUEUE_CNT_WIDTH;
    localparam logic [PW-1:0] LAST_PTR = PW'(s2i_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(s2i_pkg::QUEUE_DEPTH);

    s2i_pkg::s2i_class_t entry_reg [s2i_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic push;
    logic pop;

    assign in_ready  = (cnt_reg != FULL_CNT);
    assign out_valid = (cnt_reg != '0);
    assign out_entry = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

`default_nettype wire

// ===== src/s2i_back.sv =====
// back end: parse state machine with multiply-add and result register
// depends on s2i_pkg and string_to_integer_parser_assert.svh
`default_nettype none
`include "string_to_integer_parser_assert.svh"

module s2i_back #(
    parameter int COUNT_WIDTH = s2i_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    input  wire s2i_pkg::s2i_class_t  q_entry,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output s2i_pkg::s2i_out_t         m_data
);

    localparam int VW = s2i_pkg::VALUE_WIDTH;
    localparam int BW = s2i_pkg::BASE_WIDTH;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGIT
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic                   neg_reg, neg_next;
    logic [VW-1:0]          acc_reg, acc_next;
    logic [BW-1:0]          base_reg, base_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   any_reg, any_next;
    logic                   m_valid_reg;
    s2i_pkg::s2i_out_t      m_data_reg;

    phase_t                 cur_phase;
    logic                   cur_neg;
    logic [VW-1:0]          cur_acc;
    logic [BW-1:0]          cur_base;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic                   cur_any;
    logic [COUNT_WIDTH-1:0] bumped;
    logic [BW-1:0]          mul_base;
    logic                   first_path;
    logic                   digit_path;
    logic                   emit;
    logic                   out_free;
    logic                   take;
    s2i_pkg::s2i_out_t      result;

    // a start byte restarts the parse before it is interpreted
    always_comb begin
        cur_phase = phase_reg;
        cur_neg   = neg_reg;
        cur_acc   = acc_reg;
        cur_base  = base_reg;
        cur_count = count_reg;
        cur_any   = any_reg;
        if (q_entry.start) begin
            cur_phase = PH_SPACE;
            cur_neg   = 1'b0;
            cur_acc   = '0;
            cur_base  = q_entry.base;
            cur_count = '0;
            cur_any   = 1'b0;
        end
    end

    // saturating character count
    assign bumped = (cur_count != '1) ? cur_count + COUNT_WIDTH'(1) : cur_count;

    // parse step
    always_comb begin
        phase_next = cur_phase;
        neg_next   = cur_neg;
        acc_next   = cur_acc;
        base_next  = cur_base;
        count_next = cur_count;
        any_next   = cur_any;
        mul_base   = cur_base;
        first_path = 1'b0;
        digit_path = 1'b0;
        emit       = 1'b0;
        case (cur_phase)
            PH_SPACE: begin
                if (q_entry.is_space) begin
                    count_next = bumped;
                end else if (q_entry.is_sign) begin
                    neg_next   = q_entry.is_minus;
                    count_next = bumped;
                    phase_next = PH_SIGNED;
                end else begin
                    first_path = 1'b1;
                end
            end
            PH_SIGNED: begin
                first_path = 1'b1;
            end
            PH_ZERO: begin
                if (q_entry.is_x) begin
                    base_next  = s2i_pkg::BASE_HEX;
                    any_next   = 1'b0;
                    acc_next   = '0;
                    count_next = bumped;
                    phase_next = PH_DIGIT;
                end else begin
                    mul_base   = (cur_base == s2i_pkg::BASE_AUTO) ? s2i_pkg::BASE_OCT
                                                                   : cur_base;
                    digit_path = 1'b1;
                end
            end
            PH_DIGIT: begin
                digit_path = 1'b1;
            end
            default: begin
            end
        endcase

        // first character after whitespace and sign: leading zero or radix default
        if (first_path) begin
            if (((cur_base == s2i_pkg::BASE_AUTO) || (cur_base == s2i_pkg::BASE_HEX)) &&
                q_entry.is_zero) begin
                acc_next   = '0;
                any_next   = 1'b1;
                count_next = bumped;
                phase_next = PH_ZERO;
            end else begin
                mul_base   = (cur_base == s2i_pkg::BASE_AUTO) ? s2i_pkg::BASE_DEC : cur_base;
                digit_path = 1'b1;
            end
        end

        // digit accumulate or end of parse
        if (digit_path) begin
            base_next = mul_base;
            if (!q_entry.is_digit || (q_entry.digit_val >= mul_base)) begin
                emit       = 1'b1;
                phase_next = PH_DONE;
            end else begin
                acc_next   = cur_acc * VW'(mul_base) + VW'(q_entry.digit_val);
                any_next   = 1'b1;
                count_next = bumped;
                phase_next = PH_DIGIT;
            end
        end
    end

    // result of an ending character
    always_comb begin
        result.parsed_value   = cur_neg ? -cur_acc : cur_acc;
        result.digits_seen    = cur_any;
        result.chars_consumed = cur_any ? s2i_pkg::CHARS_WIDTH'(cur_count) : '0;
    end

    // an entry that ends the parse waits for room in the result register
    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = !emit || out_free;
    assign take     = q_valid && q_ready;

    // parse state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_DONE;
            neg_reg     <= 1'b0;
            base_reg    <= '0;
            count_reg   <= '0;
            any_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                base_reg  <= base_next;
                count_reg <= count_next;
                any_reg   <= any_next;
            end
            if (take && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (take) begin
            acc_reg <= acc_next;
        end
        if (take && emit) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `S2I_ASSERT_SAME(a_no_digit_no_count, aclk, aresetn, m_valid_reg && !m_data_reg.digits_seen, m_data_reg.chars_consumed == '0)
    `S2I_ASSERT_NEXT(a_emit_loads_output, aclk, aresetn, take && emit, m_valid_reg)
    `S2I_ASSERT_NEXT(a_done_is_silent, aclk, aresetn, take && !q_entry.start && (phase_reg == PH_DONE) && !m_valid_reg, !m_valid_reg)
    `S2I_ASSERT_NEXT(a_start_leaves_done, aclk, aresetn, take && q_entry.start && !emit, phase_reg != PH_DONE)

endmodule

`default_nettype wire

// ===== src/string_to_integer_parser.sv =====
// top level of the streaming string-to-integer parser
// depends on s2i_pkg, s2i_front, s2i_queue and s2i_back
//
//  port group   direction  handshake                       payload
//  s_*          in         s_valid / s_ready               s_data  (s2i_in_t)
//  m_*          out        m_valid / m_ready               m_data  (s2i_out_t)
//  p*           in/out     psel+penable+pwrite, pready=1   pwdata / prdata
//
// one character per cycle sustained while m_ready keeps the result register free; the back end's
// 64-by-6 multiply-add on the accumulator sets this, one classified character per cycle.
// m_valid rises after the ending character is accepted, once it has passed the queue
// register and has then been loaded into the result register.
// reset is synchronous and needs no clearing pass; the block takes items right after.
// a stalled result holds the back end only at an ending character; the two-entry
// queue then takes at most one more character before s_ready drops.
`default_nettype none

module string_to_integer_parser #(
    parameter int COUNT_WIDTH = s2i_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire s2i_pkg::s2i_in_t                     s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output s2i_pkg::s2i_out_t                         m_data,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [s2i_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [s2i_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [s2i_pkg::APB_DATA_WIDTH-1:0]        prdata,
    output logic                                      pready
);

    logic [s2i_pkg::BASE_WIDTH-1:0] number_base_reg;
    logic                           reg_hit;
    s2i_pkg::s2i_class_t            front_cls;
    s2i_pkg::s2i_class_t            q_entry;
    logic                           q_valid;
    logic                           q_ready;

    // register decode
    assign pready  = 1'b1;
    assign reg_hit = (paddr[s2i_pkg::APB_ADDR_WIDTH-1:2] == s2i_pkg::REG_NUMBER_BASE);
    assign prdata  = reg_hit ? s2i_pkg::APB_DATA_WIDTH'(number_base_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_base_reg <= s2i_pkg::BASE_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            number_base_reg <= pwdata[s2i_pkg::BASE_WIDTH-1:0];
        end
    end

    // classify
    s2i_front u_front (
        .in_data     (s_data),
        .number_base (number_base_reg),
        .cls         (front_cls)
    );

    // decoupling queue
    s2i_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_entry  (front_cls),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_entry (q_entry)
    );

    // parse engine
    s2i_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_entry (q_entry),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
